/* src/spc_pkg.sv */
// spc_pkg: widths, codes, latencies and stage payload structs for the sphere pair
// contact pipeline. No dependencies; imported by every module of the block.
package spc_pkg;

    localparam int CoordW = 32;
    localparam int RadW   = 30;
    localparam int SepW   = 16;
    localparam int NormW  = 18;
    localparam int ImpW   = 31;
    localparam int StatW  = 2;
    localparam int MagW   = 31;   // |d| component once far pairs are dropped
    localparam int SumW   = 31;   // own + rival radius
    localparam int SqW    = 62;
    localparam int D2W    = 64;
    localparam int DistW  = 32;
    localparam int NumW   = 48;
    localparam int QW     = 17;
    localparam int ProdW  = 47;
    localparam int RemW   = 36;   // square root partial remainder
    localparam int IdxW   = 2;
    localparam int CfgW   = 32;

    localparam int SqrtLat = DistW;
    localparam int DivLat  = QW;

    localparam logic [StatW-1:0] ST_NONE  = 2'd0;
    localparam logic [StatW-1:0] ST_HIT   = 2'd1;
    localparam logic [StatW-1:0] ST_COINC = 2'd2;

    localparam logic [IdxW-1:0] REG_OWN_RADIUS = 2'd0;
    localparam logic [IdxW-1:0] REG_MIN_SEP    = 2'd1;

    localparam logic [RadW-1:0] OWN_RADIUS_RST = 30'd65536;
    localparam logic [SepW-1:0] MIN_SEP_RST    = 16'd1;

    typedef struct packed {
        logic                       hit;
        logic [2:0]                 neg;
        logic [2:0][MagW-1:0]       mag;
        logic [2:0][CoordW-1:0]     rc;
        logic [RadW-1:0]            rr;
        logic [SumW-1:0]            big_r;
    } spc_mid_t;

    typedef struct packed {
        logic [StatW-1:0]           status;
        logic [2:0]                 neg;
        logic [2:0][CoordW-1:0]     rc;
        logic [RadW-1:0]            rr;
        logic [ImpW-1:0]            impact;
    } spc_tail_t;

endpackage

/* src/spc_sqrt.sv */
// spc_sqrt: pipelined integer square root, one result bit per stage.
// Depends on spc_pkg for widths and latency.
module spc_sqrt (
    input  logic                      aclk,
    input  logic                      ce,
    input  logic [spc_pkg::D2W-1:0]   x_in,
    output logic [spc_pkg::DistW-1:0] root_out
);
    import spc_pkg::*;

    logic [D2W-1:0]   x_reg    [SqrtLat];
    logic [RemW-1:0]  rem_reg  [SqrtLat];
    logic [DistW-1:0] root_reg [SqrtLat];

    genvar s;
    for (s = 0; s < SqrtLat; s++) begin : g_st
        logic [D2W-1:0]   x_prev;
        logic [RemW-1:0]  rem_prev;
        logic [DistW-1:0] root_prev;
        logic [RemW-1:0]  rem_sh;
        logic [RemW-1:0]  test;
        logic             take;

        if (s == 0) begin : g_first
            assign x_prev    = x_in;
            assign rem_prev  = '0;
            assign root_prev = '0;
        end else begin : g_next
            assign x_prev    = x_reg[s-1];
            assign rem_prev  = rem_reg[s-1];
            assign root_prev = root_reg[s-1];
        end

        // bring down the next bit pair and try root*4+1
        assign rem_sh = {rem_prev[RemW-3:0], x_prev[D2W-1-2*s -: 2]};
        assign test   = {2'b00, root_prev, 2'b01};
        assign take   = (rem_sh >= test);

        always_ff @(posedge aclk) begin
            if (ce) begin
                x_reg[s]    <= x_prev;
                rem_reg[s]  <= take ? (rem_sh - test) : rem_sh;
                root_reg[s] <= {root_prev[DistW-2:0], take};
            end
        end
    end

    assign root_out = root_reg[SqrtLat-1];

endmodule

/* src/spc_div.sv */
// spc_div: pipelined restoring divider, one quotient bit per stage, for the
// normal components. Depends on spc_pkg. Quotient must fit in QW bits.
module spc_div (
    input  logic                      aclk,
    input  logic                      ce,
    input  logic [spc_pkg::NumW-1:0]  num_in,
    input  logic [spc_pkg::DistW-1:0] den_in,
    output logic [spc_pkg::QW-1:0]    quo_out
);
    import spc_pkg::*;

    logic [NumW-1:0]  rem_reg [DivLat];
    logic [DistW-1:0] den_reg [DivLat];
    logic [QW-1:0]    quo_reg [DivLat];

    genvar s;
    for (s = 0; s < DivLat; s++) begin : g_st
        logic [NumW-1:0]  rem_prev;
        logic [DistW-1:0] den_prev;
        logic [QW-1:0]    quo_prev;
        logic [NumW:0]    den_sh;
        logic             take;

        if (s == 0) begin : g_first
            assign rem_prev = num_in;
            assign den_prev = den_in;
            assign quo_prev = '0;
        end else begin : g_next
            assign rem_prev = rem_reg[s-1];
            assign den_prev = den_reg[s-1];
            assign quo_prev = quo_reg[s-1];
        end

        assign den_sh = {{(NumW+1-DistW){1'b0}}, den_prev} << (QW-1-s);
        assign take   = ({1'b0, rem_prev} >= den_sh);

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[s] <= take ? (rem_prev - den_sh[NumW-1:0]) : rem_prev;
                den_reg[s] <= den_prev;
                quo_reg[s] <= {quo_prev[QW-2:0], take};
            end
        end
    end

    assign quo_out = quo_reg[DivLat-1];

endmodule

/* src/sphere_pair_contact.sv */
// sphere_pair_contact: streaming sphere/sphere contact test, top level.
// Depends on spc_pkg, spc_sqrt and spc_div.
//
//  channel   direction  handshake               word
//  s_        in         s_tvalid / s_tready     one sphere pair
//  m_        out        m_tvalid / m_tready     one contact result
//  cfg_      in         cfg_valid / cfg_ready   register index and value
//
// One word enters per cycle while m_ is not stalled. Each word passes three front
// stages, 32 square-root stages, one set-up stage, 17 divider stages and two back
// stages before its result leaves; the square-root and divider chains are most of that path.
// aresetn (synchronous, active low) clears the valid bits and the registers to
// own_radius 1.0 and min_separation 1 lsb.
// A stall on m_ holds the whole pipeline in place: nothing is lost or repeated.
module sphere_pair_contact (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // own_x, own_y, own_z, rival_x, rival_y, rival_z, rival_radius, 2 zero bits
    input  logic [223:0]                s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // status, normal_x, normal_y, normal_z, impact, point_x, point_y, point_z, 1 zero bit
    output logic [183:0]                m_tdata,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [spc_pkg::IdxW-1:0]    cfg_index,
    input  logic [spc_pkg::CfgW-1:0]    cfg_data
);
    import spc_pkg::*;

    logic                ce;
    logic [RadW-1:0]     own_radius_reg;
    logic [SepW-1:0]     min_sep_reg;

    // advance everything whenever the output slot is free or being emptied
    assign ce        = !m_tvalid || m_tready;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_radius_reg <= OWN_RADIUS_RST;
            min_sep_reg    <= MIN_SEP_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_OWN_RADIUS: own_radius_reg <= cfg_data[RadW-1:0];
                REG_MIN_SEP:    min_sep_reg    <= cfg_data[SepW-1:0];
                default: ;
            endcase
        end
    end

    // ---- stage 1: differences and magnitudes ----
    logic [2:0][CoordW-1:0] own_c, riv_c;
    logic [RadW-1:0]        rr_in;
    spc_mid_t               mid1_next, mid1_reg;
    logic                   far1_next, far1_reg, v1_reg;

    always_comb begin
        logic [CoordW:0] dif;
        logic [CoordW:0] mg;
        mid1_next = '0;
        far1_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            own_c[i] = s_tdata[CoordW*i +: CoordW];
            riv_c[i] = s_tdata[CoordW*(3+i) +: CoordW];
        end
        rr_in = s_tdata[CoordW*6 +: RadW];
        for (int i = 0; i < 3; i++) begin
            dif = {own_c[i][CoordW-1], own_c[i]} - {riv_c[i][CoordW-1], riv_c[i]};
            mg  = dif[CoordW] ? (~dif + 1'b1) : dif;
            mid1_next.neg[i] = dif[CoordW];
            mid1_next.mag[i] = mg[MagW-1:0];
            mid1_next.rc[i]  = riv_c[i];
            // any component of 2^31 or more: too far apart to touch
            if (mg[CoordW] || mg[CoordW-1]) far1_next = 1'b1;
        end
        mid1_next.rr    = rr_in;
        mid1_next.big_r = {1'b0, own_radius_reg} + {1'b0, rr_in};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mid1_reg <= mid1_next;
            far1_reg <= far1_next;
        end
    end

    // ---- stage 2: squares ----
    logic [2:0][SqW-1:0] sq2_reg;
    logic [SqW-1:0]      r2_reg;
    spc_mid_t            mid2_reg;
    logic                far2_reg, v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ce) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                sq2_reg[i] <= mid1_reg.mag[i] * mid1_reg.mag[i];
            end
            r2_reg   <= mid1_reg.big_r * mid1_reg.big_r;
            mid2_reg <= mid1_reg;
            far2_reg <= far1_reg;
        end
    end

    // ---- stage 3: squared distance and hit test ----
    logic [D2W-1:0] d2_next, d2_reg;
    spc_mid_t       mid3_next, mid3_reg;
    logic           v3_reg;

    assign d2_next = {2'b00, sq2_reg[0]} + {2'b00, sq2_reg[1]} + {2'b00, sq2_reg[2]};

    always_comb begin
        mid3_next     = mid2_reg;
        mid3_next.hit = !far2_reg && (d2_next < {2'b00, r2_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (ce) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d2_reg   <= d2_next;
            mid3_reg <= mid3_next;
        end
    end

    // ---- square root, side data delayed alongside ----
    logic [DistW-1:0] dist_root;
    spc_mid_t         mid_d_reg [SqrtLat];
    logic [SqrtLat-1:0] vq_reg;

    spc_sqrt u_sqrt (
        .aclk     (aclk),
        .ce       (ce),
        .x_in     (d2_reg),
        .root_out (dist_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vq_reg <= '0;
        end else if (ce) begin
            vq_reg <= {vq_reg[SqrtLat-2:0], v3_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mid_d_reg[0] <= mid3_reg;
            for (int k = 1; k < SqrtLat; k++) begin
                mid_d_reg[k] <= mid_d_reg[k-1];
            end
        end
    end

    // ---- stage 4: classify, set up division ----
    spc_mid_t               mq;
    spc_tail_t              tail4_next, tail4_reg;
    logic [2:0][NumW-1:0]   num4_reg;
    logic [DistW-1:0]       dist4_reg;
    logic                   v4_reg;

    assign mq = mid_d_reg[SqrtLat-1];

    always_comb begin
        logic coinc;
        coinc = (dist_root == '0) ||
                (dist_root < {{(DistW-SepW){1'b0}}, min_sep_reg});
        tail4_next.status = !mq.hit ? ST_NONE : (coinc ? ST_COINC : ST_HIT);
        tail4_next.neg    = mq.neg;
        tail4_next.rc     = mq.rc;
        tail4_next.rr     = mq.rr;
        tail4_next.impact = mq.big_r - dist_root[ImpW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (ce) begin
            v4_reg <= vq_reg[SqrtLat-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            tail4_reg <= tail4_next;
            dist4_reg <= dist_root;
            for (int i = 0; i < 3; i++) begin
                // m * 2^16 + dist / 2 gives round to nearest after division
                num4_reg[i] <= {1'b0, mq.mag[i], 16'd0} + {17'd0, dist_root[DistW-1:1]};
            end
        end
    end

    // ---- three divider lanes ----
    logic [2:0][QW-1:0] nm;

    genvar g;
    for (g = 0; g < 3; g++) begin : g_lane
        spc_div u_div (
            .aclk    (aclk),
            .ce      (ce),
            .num_in  (num4_reg[g]),
            .den_in  (dist4_reg),
            .quo_out (nm[g])
        );
    end

    spc_tail_t        tail_d_reg [DivLat];
    logic [DivLat-1:0] vd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= '0;
        end else if (ce) begin
            vd_reg <= {vd_reg[DivLat-2:0], v4_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            tail_d_reg[0] <= tail4_reg;
            for (int k = 1; k < DivLat; k++) begin
                tail_d_reg[k] <= tail_d_reg[k-1];
            end
        end
    end

    // ---- stage 5: offset product ----
    logic [2:0][ProdW-1:0] prod5_reg;
    logic [2:0][QW-1:0]    nm5_reg;
    spc_tail_t             tail5_reg;
    logic                  v5_reg;
    spc_tail_t             td;

    assign td = tail_d_reg[DivLat-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (ce) begin
            v5_reg <= vd_reg[DivLat-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                prod5_reg[i] <= nm[i] * td.rr;
            end
            nm5_reg   <= nm;
            tail5_reg <= td;
        end
    end

    // ---- stage 6: round, sign, saturate, output register ----
    logic [183:0] out_next, out_reg;
    logic         vo_reg;

    always_comb begin
        logic [ProdW:0]   rnd;
        logic [CoordW:0]  off;
        logic [CoordW:0]  sum;
        logic [CoordW-1:0] pt;
        logic [NormW-1:0] nv;
        logic             hit;
        hit      = (tail5_reg.status == ST_HIT);
        out_next = '0;
        out_next[1:0] = tail5_reg.status;
        for (int i = 0; i < 3; i++) begin
            rnd = {1'b0, prod5_reg[i]} + 48'd32768;
            off = {1'b0, rnd[ProdW:16]};
            if (tail5_reg.neg[i]) off = ~off + 1'b1;
            nv  = tail5_reg.neg[i] ? (~{1'b0, nm5_reg[i]} + 1'b1) : {1'b0, nm5_reg[i]};
            sum = {tail5_reg.rc[i][CoordW-1], tail5_reg.rc[i]} + off;
            // clamp to the signed 32-bit range
            if (sum[CoordW] != sum[CoordW-1]) begin
                pt = sum[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
            end else begin
                pt = sum[CoordW-1:0];
            end
            if (hit) begin
                out_next[2 + NormW*i +: NormW]    = nv;
                out_next[87 + CoordW*i +: CoordW] = pt;
            end
        end
        if (hit) out_next[56 +: ImpW] = tail5_reg.impact;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (ce) begin
            vo_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    // a reported contact always has positive depth
    a_hit_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == ST_HIT) |-> (m_tdata[86:56] != '0))
        else $error("contact reported with zero depth");

    // anything but a contact carries all-zero payload
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != ST_HIT) |-> (m_tdata[183:2] == '0))
        else $error("non-contact result with non-zero payload");

    // writes to unused register indexes change nothing
    a_cfg_ignore: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && (cfg_index != REG_OWN_RADIUS) && (cfg_index != REG_MIN_SEP)
        |=> $stable(own_radius_reg) && $stable(min_sep_reg))
        else $error("register changed on unused index");
`endif

endmodule
